>>> rtl/set_assoc_cache_fifo_tag_store_defines.svh
// Assertion macros for the set-associative tag store.
`ifndef SET_ASSOC_CACHE_FIFO_TAG_STORE_DEFINES_SVH
`define SET_ASSOC_CACHE_FIFO_TAG_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SACFS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define SACFS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define SACFS_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define SACFS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> rtl/sacfs_pkg.sv
// Shared constants and types for the set-associative FIFO tag store.
`timescale 1ns / 1ps
package sacfs_pkg;

    localparam int ADDR_BITS      = 32;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_MAX_BLOCKS = 1024;
    localparam int OFF_MIN        = 5;
    localparam int OFF_MAX        = 6;
    localparam int BLK_LOG2_MIN   = 4;
    localparam int WAYS_LOG2_CAP  = 3;
    localparam int WAY_W          = 3;
    localparam int CNT_W          = 32;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_IDX_W      = 2;
    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAYS_LOG2   = 2'd0,
        REG_BLOCKS_LOG2 = 2'd1,
        REG_OFFSET_BITS = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

>>> rtl/sacfs_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module sacfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/set_assoc_cache_fifo_tag_store.sv
// Top level: set-associative tag store with FIFO replacement and hit/miss counters.
// One request at a time: in_ready is high only in S_IDLE, so no new request is taken
// until the previous result has left S_DONE; one way is compared per cycle through
// the single read port of the tag RAM, then the write-back follows in S_UPDATE.
// Reset: clears counters and control, then a clearing pass over all MAX_BLOCKS entries wipes
// valid bits and FIFO pointers; no request is taken during that pass.
`timescale 1ns / 1ps
`include "set_assoc_cache_fifo_tag_store_defines.svh"
module set_assoc_cache_fifo_tag_store #(
    parameter int MAX_WAYS   = sacfs_pkg::DEF_MAX_WAYS,
    parameter int MAX_BLOCKS = sacfs_pkg::DEF_MAX_BLOCKS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sacfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sacfs_pkg::ADDR_BITS-1:0]     address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [sacfs_pkg::WAY_W-1:0]         way,
    output logic                                evicted,
    output logic [sacfs_pkg::CNT_W-1:0]         hit_count,
    output logic [sacfs_pkg::CNT_W-1:0]         miss_count
);

    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int WL_RAW    = $clog2(MAX_WAYS + 1) - 1;
    localparam int WAYS_MAX  = (WL_RAW > sacfs_pkg::WAYS_LOG2_CAP) ?
                               sacfs_pkg::WAYS_LOG2_CAP : WL_RAW;
    localparam int TAG_W     = sacfs_pkg::ADDR_BITS -
                               (sacfs_pkg::OFF_MIN + sacfs_pkg::BLK_LOG2_MIN - WAYS_MAX);
    localparam int WAY_W     = sacfs_pkg::WAY_W;
    localparam int CNT_W     = sacfs_pkg::CNT_W;

    sacfs_pkg::state_t state_reg, state_next;

    logic [1:0]           ways_reg;
    logic [3:0]           blocks_reg;
    logic [2:0]           offset_reg;

    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [IDX_W-1:0]     set_reg;
    logic [IDX_W-1:0]     base_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [1:0]           w_reg;
    logic [WAY_W:0]       idx_reg;
    logic                 cmp_vld_reg;
    logic [WAY_W-1:0]     cmp_way_reg;
    logic                 hit_found_reg;
    logic [WAY_W-1:0]     hit_way_reg;
    logic                 inv_found_reg;
    logic [WAY_W-1:0]     inv_way_reg;
    logic                 res_hit_reg;
    logic [WAY_W-1:0]     res_way_reg;
    logic                 res_evict_reg;
    logic [CNT_W-1:0]     hits_total_reg;
    logic [CNT_W-1:0]     misses_total_reg;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [WAY_W-1:0]     out_way_reg;
    logic                 out_evict_reg;
    logic [CNT_W-1:0]     out_hits_reg;
    logic [CNT_W-1:0]     out_misses_reg;

    // address split
    logic [1:0]           eff_w;
    logic [3:0]           eff_b;
    logic [2:0]           eff_o;
    logic [3:0]           ib;
    logic [4:0]           sh;
    logic [IDX_W:0]       one_sh;
    logic [IDX_W-1:0]     set_mask;
    logic [sacfs_pkg::ADDR_BITS-1:0] addr_off;
    logic [sacfs_pkg::ADDR_BITS-1:0] addr_tag;
    logic [IDX_W-1:0]     set_c;
    logic [IDX_W-1:0]     base_c;

    // sequencing
    logic [WAY_W:0]       nways;
    logic [WAY_W-1:0]     wmask;
    logic                 scan_issue;
    logic                 in_fire;
    logic                 out_free;
    logic [WAY_W-1:0]     way_sel;
    logic                 miss_evict;

    // RAM ports
    logic                 tag_we;
    logic [IDX_W-1:0]     tag_waddr;
    logic [TAG_W:0]       tag_wdata;
    logic [IDX_W-1:0]     tag_raddr;
    logic [TAG_W:0]       tag_rdata;
    logic                 fifo_we;
    logic [IDX_W-1:0]     fifo_waddr;
    logic [WAY_W-1:0]     fifo_wdata;
    logic [WAY_W-1:0]     fifo_rdata;

    assign in_ready = (state_reg == sacfs_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        eff_w = (ways_reg > 2'(WAYS_MAX)) ? 2'(WAYS_MAX) : ways_reg;
        if (blocks_reg < 4'(sacfs_pkg::BLK_LOG2_MIN))
            eff_b = 4'(sacfs_pkg::BLK_LOG2_MIN);
        else if (blocks_reg > 4'(IDX_W))
            eff_b = 4'(IDX_W);
        else
            eff_b = blocks_reg;
        if (offset_reg < 3'(sacfs_pkg::OFF_MIN))
            eff_o = 3'(sacfs_pkg::OFF_MIN);
        else if (offset_reg > 3'(sacfs_pkg::OFF_MAX))
            eff_o = 3'(sacfs_pkg::OFF_MAX);
        else
            eff_o = offset_reg;
        ib       = eff_b - {2'b00, eff_w};
        sh       = {2'b00, eff_o} + {1'b0, ib};
        one_sh   = {{IDX_W{1'b0}}, 1'b1} << ib;
        set_mask = IDX_W'(one_sh - {{IDX_W{1'b0}}, 1'b1});
        addr_off = address >> eff_o;
        addr_tag = address >> sh;
        set_c    = addr_off[IDX_W-1:0] & set_mask;
        base_c   = set_c << eff_w;
    end

    always_comb
    begin
        nways      = {{WAY_W{1'b0}}, 1'b1} << w_reg;
        wmask      = WAY_W'(nways - {{WAY_W{1'b0}}, 1'b1});
        scan_issue = (state_reg == sacfs_pkg::S_SCAN) && (idx_reg < nways);
        miss_evict = !hit_found_reg && !inv_found_reg;
        if (hit_found_reg)
            way_sel = hit_way_reg;
        else if (inv_found_reg)
            way_sel = inv_way_reg;
        else
            way_sel = fifo_rdata & wmask;
    end

    always_comb
    begin
        tag_raddr  = base_reg + {{(IDX_W-WAY_W){1'b0}}, idx_reg[WAY_W-1:0]};
        tag_we     = 1'b0;
        tag_waddr  = base_reg + {{(IDX_W-WAY_W){1'b0}}, way_sel};
        tag_wdata  = {1'b1, tag_reg};
        fifo_we    = 1'b0;
        fifo_waddr = set_reg;
        fifo_wdata = (way_sel + {{(WAY_W-1){1'b0}}, 1'b1}) & wmask;
        case (state_reg)
            sacfs_pkg::S_CLEAR:
            begin
                tag_we     = 1'b1;
                tag_waddr  = clr_cnt_reg;
                tag_wdata  = '0;
                fifo_we    = 1'b1;
                fifo_waddr = clr_cnt_reg;
                fifo_wdata = '0;
            end
            sacfs_pkg::S_UPDATE:
            begin
                tag_we  = !hit_found_reg;
                fifo_we = miss_evict;
            end
            default:
            begin
                tag_we  = 1'b0;
                fifo_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacfs_pkg::S_CLEAR:
                if (clr_cnt_reg == IDX_W'(MAX_BLOCKS - 1))
                    state_next = sacfs_pkg::S_IDLE;
            sacfs_pkg::S_IDLE:
                if (in_fire)
                    state_next = sacfs_pkg::S_SCAN;
            sacfs_pkg::S_SCAN:
                if (idx_reg == nways)
                    state_next = sacfs_pkg::S_UPDATE;
            sacfs_pkg::S_UPDATE:
                state_next = sacfs_pkg::S_DONE;
            sacfs_pkg::S_DONE:
                if (out_free)
                    state_next = sacfs_pkg::S_IDLE;
            default:
                state_next = sacfs_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sacfs_pkg::S_CLEAR;
            ways_reg         <= 2'd0;
            blocks_reg       <= 4'd4;
            offset_reg       <= 3'd5;
            clr_cnt_reg      <= '0;
            idx_reg          <= '0;
            cmp_vld_reg      <= 1'b0;
            hit_found_reg    <= 1'b0;
            inv_found_reg    <= 1'b0;
            hits_total_reg   <= '0;
            misses_total_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    sacfs_pkg::REG_WAYS_LOG2:   ways_reg   <= cfg_data[1:0];
                    sacfs_pkg::REG_BLOCKS_LOG2: blocks_reg <= cfg_data[3:0];
                    sacfs_pkg::REG_OFFSET_BITS: offset_reg <= cfg_data[2:0];
                    default:                    ways_reg   <= ways_reg;
                endcase
            end

            if (state_reg == sacfs_pkg::S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + {{(IDX_W-1){1'b0}}, 1'b1};

            if (in_fire)
            begin
                idx_reg       <= '0;
                hit_found_reg <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            else if (state_reg == sacfs_pkg::S_SCAN)
            begin
                idx_reg <= idx_reg + {{WAY_W{1'b0}}, 1'b1};
            end

            cmp_vld_reg <= scan_issue;
            if (cmp_vld_reg)
            begin
                if (tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == tag_reg) && !hit_found_reg)
                    hit_found_reg <= 1'b1;
                if (!tag_rdata[TAG_W] && !inv_found_reg)
                    inv_found_reg <= 1'b1;
            end

            if (state_reg == sacfs_pkg::S_UPDATE)
            begin
                if (hit_found_reg)
                begin
                    if (hits_total_reg != sacfs_pkg::COUNT_MAX)
                        hits_total_reg <= hits_total_reg + 32'd1;
                end
                else if (misses_total_reg != sacfs_pkg::COUNT_MAX)
                begin
                    misses_total_reg <= misses_total_reg + 32'd1;
                end
            end

            if ((state_reg == sacfs_pkg::S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg  <= set_c;
            base_reg <= base_c;
            tag_reg  <= addr_tag[TAG_W-1:0];
            w_reg    <= eff_w;
        end
        cmp_way_reg <= idx_reg[WAY_W-1:0];
        if (cmp_vld_reg)
        begin
            if (tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == tag_reg) && !hit_found_reg)
                hit_way_reg <= cmp_way_reg;
            if (!tag_rdata[TAG_W] && !inv_found_reg)
                inv_way_reg <= cmp_way_reg;
        end
        if (state_reg == sacfs_pkg::S_UPDATE)
        begin
            res_hit_reg   <= hit_found_reg;
            res_way_reg   <= way_sel;
            res_evict_reg <= miss_evict;
        end
        if ((state_reg == sacfs_pkg::S_DONE) && out_free)
        begin
            out_hit_reg    <= res_hit_reg;
            out_way_reg    <= res_way_reg;
            out_evict_reg  <= res_evict_reg;
            out_hits_reg   <= hits_total_reg;
            out_misses_reg <= misses_total_reg;
        end
    end

    sacfs_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    sacfs_ram #(
        .WIDTH (WAY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (set_reg),
        .rdata (fifo_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign way        = out_way_reg;
    assign evicted    = out_evict_reg;
    assign hit_count  = out_hits_reg;
    assign miss_count = out_misses_reg;

    `SACFS_ASSERT_IMPLY(a_no_req_in_clear, clk, rst_n, state_reg == sacfs_pkg::S_CLEAR, !in_ready)
    `SACFS_ASSERT_NEXT(a_req_starts_scan, clk, rst_n, in_fire, state_reg == sacfs_pkg::S_SCAN)
    `SACFS_ASSERT_IMPLY(a_hit_not_evict, clk, rst_n, out_valid_reg, !(out_hit_reg && out_evict_reg))
    `SACFS_ASSERT_NEXT(a_hits_monotonic, clk, rst_n, 1'b1, hits_total_reg >= $past(hits_total_reg))

endmodule
